@@ hdl/whp_pkg.sv @@
`timescale 1ns / 1ps
// whp_pkg: types and constants of the wav header parser
// item structs, parse phases, parser state and the fixed tag values; no dependencies

package whp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  parse_status;
    logic [7:0]  channel_count;
    logic [31:0] sample_rate;
    logic [1:0]  sample_type;
    logic        is_adpcm;
    logic [15:0] adpcm_block_bytes;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_RIFF   = 4'd0,
    PH_FSIZE  = 4'd1,
    PH_WAVE   = 4'd2,
    PH_TAG    = 4'd3,
    PH_CSIZE  = 4'd4,
    PH_SKIP   = 4'd5,
    PH_FTYPE  = 4'd6,
    PH_FCHAN  = 4'd7,
    PH_FRATE  = 4'd8,
    PH_FAVG   = 4'd9,
    PH_FALIGN = 4'd10,
    PH_FBITS  = 4'd11,
    PH_XSIZE  = 4'd12
  } phase_e;

  typedef struct packed {
    phase_e      parse_phase;
    logic [1:0]  field_byte_index;
    logic [31:0] field_assembly;
    logic [31:0] skip_remaining;
    logic [31:0] byte_position;
    logic [15:0] format_code;
    logic [7:0]  held_channels;
    logic [31:0] held_rate;
    logic [15:0] held_block_align;
    logic [1:0]  held_sample_type;
    logic        held_adpcm;
    logic [31:0] chunk_tag;
    logic        parse_done;
  } state_t;

  localparam state_t STATE_RESET = '{
    parse_phase:      PH_RIFF,
    field_byte_index: 2'd0,
    field_assembly:   32'd0,
    skip_remaining:   32'd0,
    byte_position:    32'd0,
    format_code:      16'd0,
    held_channels:    8'd0,
    held_rate:        32'd0,
    held_block_align: 16'd0,
    held_sample_type: 2'd0,
    held_adpcm:       1'b0,
    chunk_tag:        32'd0,
    parse_done:       1'b0
  };

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM       = 16'd1;
  localparam logic [15:0] FMT_FLOAT     = 16'd3;
  localparam logic [15:0] FMT_IMA_ADPCM = 16'd17;

  localparam logic [15:0] BITS_8  = 16'd8;
  localparam logic [15:0] BITS_16 = 16'd16;
  localparam logic [15:0] BITS_32 = 16'd32;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RIFF   = 3'd1;
  localparam logic [2:0] ST_NO_WAVE   = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  localparam logic [1:0] SMP_U8  = 2'd0;
  localparam logic [1:0] SMP_S16 = 2'd1;
  localparam logic [1:0] SMP_S32 = 2'd2;
  localparam logic [1:0] SMP_F32 = 2'd3;

endpackage

@@ hdl/whp_step.sv @@
`timescale 1ns / 1ps
// whp_step: next parser state and result for one stream byte
// purely combinational; depends on whp_pkg

module whp_step (
  input  whp_pkg::state_t    state_i,
  input  whp_pkg::in_item_t  item_i,
  output whp_pkg::state_t    state_o,
  output logic               emit_o,
  output whp_pkg::out_item_t result_o
);

  always_comb begin
    whp_pkg::state_t s;
    logic [31:0] v;
    logic [15:0] bits;
    logic [2:0]  status;
    logic        short_f;
    logic        bad;
    logic        ok;
    logic        emit;

    v       = '0;
    bits    = '0;
    status  = whp_pkg::ST_OK;
    short_f = 1'b0;
    bad     = 1'b0;
    ok      = 1'b0;
    emit    = 1'b0;
    s       = item_i.first_byte ? whp_pkg::STATE_RESET : state_i;

    if (!s.parse_done) begin
      s.byte_position = s.byte_position + 32'd1;
      if (s.parse_phase == whp_pkg::PH_SKIP) begin
        if (s.skip_remaining != 32'd0) begin
          s.skip_remaining = s.skip_remaining - 32'd1;
        end
        if (s.skip_remaining == 32'd0) begin
          s.parse_phase = whp_pkg::PH_TAG;
        end
      end else begin
        if (s.field_byte_index == 2'd0) begin
          s.field_assembly = {24'd0, item_i.byte_value};
        end else begin
          s.field_assembly[{s.field_byte_index, 3'b000} +: 8] = item_i.byte_value;
        end
        short_f = s.parse_phase inside {whp_pkg::PH_FTYPE, whp_pkg::PH_FCHAN,
                                        whp_pkg::PH_FALIGN, whp_pkg::PH_FBITS,
                                        whp_pkg::PH_XSIZE};
        if (s.field_byte_index != (short_f ? 2'd1 : 2'd3)) begin
          s.field_byte_index = s.field_byte_index + 2'd1;
        end else begin
          v = s.field_assembly;
          s.field_byte_index = 2'd0;
          case (s.parse_phase)
            whp_pkg::PH_RIFF: begin
              if (v != whp_pkg::TAG_RIFF) begin
                emit   = 1'b1;
                status = whp_pkg::ST_NO_RIFF;
              end else begin
                s.parse_phase = whp_pkg::PH_FSIZE;
              end
            end
            whp_pkg::PH_FSIZE: s.parse_phase = whp_pkg::PH_WAVE;
            whp_pkg::PH_WAVE: begin
              if (v != whp_pkg::TAG_WAVE) begin
                emit   = 1'b1;
                status = whp_pkg::ST_NO_WAVE;
              end else begin
                s.parse_phase = whp_pkg::PH_TAG;
              end
            end
            whp_pkg::PH_TAG: begin
              s.chunk_tag   = v;
              s.parse_phase = whp_pkg::PH_CSIZE;
            end
            whp_pkg::PH_CSIZE: begin
              if (s.chunk_tag == whp_pkg::TAG_FMT) begin
                s.parse_phase = whp_pkg::PH_FTYPE;
              end else if (s.chunk_tag == whp_pkg::TAG_DATA) begin
                emit   = 1'b1;
                ok     = 1'b1;
                status = whp_pkg::ST_OK;
              end else begin
                s.skip_remaining = v;
                s.parse_phase    = (v != 32'd0) ? whp_pkg::PH_SKIP : whp_pkg::PH_TAG;
              end
            end
            whp_pkg::PH_FTYPE: begin
              s.format_code = v[15:0];
              s.parse_phase = whp_pkg::PH_FCHAN;
            end
            whp_pkg::PH_FCHAN: begin
              s.held_channels = v[7:0];
              s.parse_phase   = whp_pkg::PH_FRATE;
            end
            whp_pkg::PH_FRATE: begin
              s.held_rate   = v;
              s.parse_phase = whp_pkg::PH_FAVG;
            end
            whp_pkg::PH_FAVG: s.parse_phase = whp_pkg::PH_FALIGN;
            whp_pkg::PH_FALIGN: begin
              s.held_block_align = v[15:0];
              s.parse_phase      = whp_pkg::PH_FBITS;
            end
            whp_pkg::PH_FBITS: begin
              bits = v[15:0];
              if (s.format_code == whp_pkg::FMT_PCM) begin
                if (bits == whp_pkg::BITS_8) begin
                  s.held_sample_type = whp_pkg::SMP_U8;
                end else if (bits == whp_pkg::BITS_16) begin
                  s.held_sample_type = whp_pkg::SMP_S16;
                end else if (bits == whp_pkg::BITS_32) begin
                  s.held_sample_type = whp_pkg::SMP_S32;
                end else begin
                  bad = 1'b1;
                end
                s.held_adpcm  = 1'b0;
                s.parse_phase = whp_pkg::PH_TAG;
              end else if (s.format_code == whp_pkg::FMT_FLOAT) begin
                if (bits == whp_pkg::BITS_32) begin
                  s.held_sample_type = whp_pkg::SMP_F32;
                end else begin
                  bad = 1'b1;
                end
                s.held_adpcm  = 1'b0;
                s.parse_phase = whp_pkg::PH_TAG;
              end else if (s.format_code == whp_pkg::FMT_IMA_ADPCM) begin
                s.held_sample_type = whp_pkg::SMP_S16;
                s.held_adpcm       = 1'b1;
                s.parse_phase      = whp_pkg::PH_XSIZE;
              end else begin
                bad = 1'b1;
              end
              if (bad) begin
                emit   = 1'b1;
                status = whp_pkg::ST_BAD_FMT;
              end
            end
            whp_pkg::PH_XSIZE: begin
              s.skip_remaining = {16'd0, v[15:0]};
              s.parse_phase    = (v[15:0] != 16'd0) ? whp_pkg::PH_SKIP : whp_pkg::PH_TAG;
            end
            default: s.parse_phase = whp_pkg::PH_RIFF;
          endcase
        end
      end

      if (!emit && item_i.last_byte) begin
        emit   = 1'b1;
        status = whp_pkg::ST_TRUNCATED;
      end
      if (emit) begin
        s.parse_done = 1'b1;
      end
    end

    state_o = s;
    emit_o  = emit;

    result_o.parse_status      = status;
    result_o.channel_count     = ok ? s.held_channels : 8'd0;
    result_o.sample_rate       = ok ? s.held_rate : 32'd0;
    result_o.sample_type       = ok ? s.held_sample_type : 2'd0;
    result_o.is_adpcm          = ok ? s.held_adpcm : 1'b0;
    result_o.adpcm_block_bytes = (ok && s.held_adpcm) ? s.held_block_align : 16'd0;
    result_o.data_offset       = ok ? s.byte_position : 32'd0;
    result_o.data_length       = ok ? s.field_assembly : 32'd0;
  end

endmodule

@@ hdl/wav_header_parser.sv @@
`timescale 1ns / 1ps
// wav_header_parser: byte-serial riff/wave header parser, top level
// input register, parser state, result register; uses whp_pkg and whp_step
//
//   port group  direction  item         handshake
//   in_*        in         in_item_t    in_valid_i / in_stall_o
//   out_*       out        out_item_t   out_valid_o / out_stall_i
//
// one byte per cycle unless output stalls; results pass input then result register
// reset returns to the riff tag phase with everything cleared, empty registers
// stall on the output only holds the input when a byte in the input register
// would produce a result while the result register is full and stalled

module wav_header_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  whp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output whp_pkg::out_item_t out_item_o
);

  logic               stg_valid_q;
  whp_pkg::in_item_t  stg_item_q;
  whp_pkg::state_t    state_q;
  whp_pkg::state_t    state_d;
  logic               out_valid_q;
  whp_pkg::out_item_t out_item_q;
  whp_pkg::out_item_t result;
  logic               emit;
  logic               out_free;
  logic               advance;
  logic               accept_in;

  whp_step u_step (
    .state_i  (state_q),
    .item_i   (stg_item_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = stg_valid_q && (!emit || out_free);
  assign in_stall_o = stg_valid_q && !advance;
  assign accept_in  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (accept_in) begin
      stg_valid_q <= 1'b1;
    end else if (advance) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      stg_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whp_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
